[src/hamming_15_11_decode_byte_pack_assert.svh]
// Assertion macros for the Hamming decoder and byte packer
`ifndef HAMMING_15_11_DECODE_BYTE_PACK_ASSERT_SVH
`define HAMMING_15_11_DECODE_BYTE_PACK_ASSERT_SVH

// same-cycle implication
`define HDBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HDBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/hdbp_pkg.sv]
`default_nettype none

package hdbp_pkg;

    localparam int CW_BITS   = 15;
    localparam int DATA_BITS = 11;
    localparam int BYTE_BITS = 8;
    localparam int SYN_BITS  = 4;
    localparam int LEFT_BITS = 7;
    localparam int ACC_BITS  = LEFT_BITS + DATA_BITS;
    localparam int CNT_BITS  = 5;

    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic [SYN_BITS-1:0]  syndrome;
        logic                 stream_end;
    } entry_t;

    typedef struct packed {
        logic                busy;
        logic [CNT_BITS-1:0] bit_count;
    } pack_status_t;

    function automatic logic [SYN_BITS-1:0] calc_syndrome(input logic [CW_BITS-1:0] cw);
        logic [SYN_BITS-1:0] s;
        s = '0;
        for (int k = 0; k < CW_BITS; k++) begin
            if (cw[k]) begin
                s = s ^ SYN_BITS'(k + 1);
            end
        end
        return s;
    endfunction

    function automatic logic [DATA_BITS-1:0] extract_data(input logic [CW_BITS-1:0] cw);
        logic [DATA_BITS-1:0] d;
        d = '0;
        for (int p = 1; p <= CW_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                d = {d[DATA_BITS-2:0], cw[p-1]};
            end
        end
        return d;
    endfunction

    function automatic entry_t decode(input logic [CW_BITS-1:0] cw, input logic last);
        entry_t               e;
        logic [SYN_BITS-1:0]  s;
        logic [CW_BITS-1:0]   fixed;
        s     = calc_syndrome(cw);
        fixed = cw;
        if (s != '0) begin
            fixed = cw ^ (CW_BITS'(1) << (s - SYN_BITS'(1)));
        end
        e.data       = extract_data(fixed);
        e.syndrome   = s;
        e.stream_end = last;
        return e;
    endfunction

endpackage

`default_nettype wire

[src/hdbp_front.sv]
`default_nettype none

module hdbp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [hdbp_pkg::CW_BITS-1:0]  codeword,
    input  wire logic                          stream_end,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output hdbp_pkg::entry_t                   push_entry
);

    logic             valid_reg;
    logic             valid_next;
    hdbp_pkg::entry_t entry_reg;
    logic             accept;

    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            entry_reg <= hdbp_pkg::decode(codeword, stream_end);
        end
    end

endmodule

`default_nettype wire

[src/hdbp_queue.sv]
`default_nettype none

module hdbp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire hdbp_pkg::entry_t  wr_entry,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output hdbp_pkg::entry_t       rd_entry,
    output logic [$clog2(DEPTH+1)-1:0] fill
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hdbp_pkg::entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_entry = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign fill     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

[src/hdbp_back.sv]
`default_nettype none

module hdbp_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire hdbp_pkg::entry_t               pop_entry,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [hdbp_pkg::BYTE_BITS-1:0]      data_byte,
    output logic [hdbp_pkg::SYN_BITS-1:0]       syndrome,
    output logic                                run_last,
    output logic                                final_byte,
    output hdbp_pkg::pack_status_t              status
);

    localparam int AW = hdbp_pkg::ACC_BITS;
    localparam int CW = hdbp_pkg::CNT_BITS;
    localparam int LW = hdbp_pkg::LEFT_BITS;
    localparam int BW = hdbp_pkg::BYTE_BITS;

    logic [AW-1:0]                    acc_reg, acc_next;
    logic [CW-1:0]                    n_reg, n_next;
    logic [hdbp_pkg::SYN_BITS-1:0]    syn_reg;
    logic                             end_reg;
    logic                             busy_reg, busy_next;
    logic                             out_valid_reg, out_valid_next;
    logic [BW-1:0]                    byte_reg;
    logic [hdbp_pkg::SYN_BITS-1:0]    osyn_reg;
    logic                             last_reg;
    logic                             final_reg;

    logic          advance;
    logic          emit;
    logic          full;
    logic [CW-1:0] n_after;
    logic [BW-1:0] byte_full;
    logic [BW-1:0] byte_pad;
    logic          last;
    logic          finish;
    logic          take;
    logic [LW-1:0] left_bits;
    logic [2:0]    left_cnt;

    assign advance   = !out_valid_reg || out_ready;
    assign emit      = busy_reg && advance;
    assign full      = n_reg >= CW'(BW);
    assign n_after   = full ? n_reg - CW'(BW) : '0;
    assign byte_full = BW'(acc_reg >> (n_reg - CW'(BW)));
    assign byte_pad  = acc_reg[BW-1:0] << (4'(BW) - {1'b0, n_reg[2:0]});
    assign last      = !full || ((n_after < CW'(BW)) && !(end_reg && n_after != '0));
    assign finish    = emit && last;
    assign pop_ready = !busy_reg || finish;
    assign take      = pop_valid && pop_ready;

    always_comb begin
        left_bits = acc_reg[LW-1:0];
        left_cnt  = n_reg[2:0];
        if (finish) begin
            if (end_reg) begin
                left_bits = '0;
                left_cnt  = '0;
            end else begin
                left_bits = acc_reg[LW-1:0] & ~(LW'({LW{1'b1}}) << n_after[2:0]);
                left_cnt  = n_after[2:0];
            end
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        if (take) begin
            acc_next  = {left_bits, pop_entry.data};
            n_next    = CW'(left_cnt) + CW'(hdbp_pkg::DATA_BITS);
            busy_next = 1'b1;
        end else if (finish) begin
            acc_next  = AW'(left_bits);
            n_next    = CW'(left_cnt);
            busy_next = 1'b0;
        end else if (emit) begin
            n_next = n_after;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            acc_reg       <= '0;
            n_reg         <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            n_reg         <= n_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (take) begin
            syn_reg <= pop_entry.syndrome;
            end_reg <= pop_entry.stream_end;
        end
        if (emit) begin
            byte_reg  <= full ? byte_full : byte_pad;
            osyn_reg  <= syn_reg;
            last_reg  <= last;
            final_reg <= last && end_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign data_byte        = byte_reg;
    assign syndrome         = osyn_reg;
    assign run_last         = last_reg;
    assign final_byte       = final_reg;
    assign status.busy      = busy_reg;
    assign status.bit_count = n_reg;

endmodule

`default_nettype wire

[src/hamming_15_11_decode_byte_pack.sv]
// Hamming (15,11) decoder with byte packing.
// Input channel (in_valid/in_ready): one 15-bit codeword per item, bit 0 is
// position 1, plus stream_end on the last codeword of a stream.
// Output channel (out_valid/out_ready): one byte per item, first stream bit
// in bit 7, with the codeword's syndrome, run_last on the last byte of a
// codeword and final_byte on the last byte of the stream.
// Each codeword yields one to three bytes; a stream_end codeword flushes the
// partial byte, left-aligned and zero-padded.
// The front stage corrects and extracts the data bits into a register and pushes
// them into a QUEUE_DEPTH-entry queue; the packer pops one entry and emits
// one byte per cycle into the output register while the receiver does not hold it.
// The first byte of a codeword passes the front register, the queue, the
// packer accumulator and the output register. Throughput: one byte per cycle
// at the output port while the queue has entries and out_ready is high.
// When the receiver stalls, the output register holds, the packer stops and
// the queue and front stage fill before in_ready drops.
// Reset empties the queue and clears the pending bits and their count.
`default_nettype none

`include "hamming_15_11_decode_byte_pack_assert.svh"

module hamming_15_11_decode_byte_pack #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [hdbp_pkg::CW_BITS-1:0]      codeword,
    input  wire logic                              stream_end,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [hdbp_pkg::BYTE_BITS-1:0]         data_byte,
    output logic [hdbp_pkg::SYN_BITS-1:0]          syndrome,
    output logic                                   run_last,
    output logic                                   final_byte
);

    logic                               push_valid;
    logic                               push_ready;
    hdbp_pkg::entry_t                   push_entry;
    logic                               pop_valid;
    logic                               pop_ready;
    hdbp_pkg::entry_t                   pop_entry;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill;
    hdbp_pkg::pack_status_t             status;

    hdbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .codeword   (codeword),
        .stream_end (stream_end),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    hdbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_entry (pop_entry),
        .fill     (fill)
    );

    hdbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .syndrome   (syndrome),
        .run_last   (run_last),
        .final_byte (final_byte),
        .status     (status)
    );

    `HDBP_ASSERT_IMPLY(a_final_is_last, clk, rst_n, out_valid && final_byte, run_last)
    `HDBP_ASSERT_IMPLY(a_idle_leftover, clk, rst_n, !status.busy,
        status.bit_count < 5'(hdbp_pkg::BYTE_BITS))
    `HDBP_ASSERT_NEXT(a_stream_flushed, clk, rst_n,
        u_back.finish && u_back.end_reg && !u_back.take, status.bit_count == '0)
    `HDBP_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1,
        fill <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))

endmodule

`default_nettype wire

[tb/sv/hamming_15_11_decode_byte_pack_test.sv]
`default_nettype none

module hamming_15_11_decode_byte_pack_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int STALL_CYCLES = 90;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [hdbp_pkg::CW_BITS-1:0] cw;
        logic                         last;
    } cw_item_t;

    typedef struct packed {
        logic [hdbp_pkg::BYTE_BITS-1:0] data_byte;
        logic [hdbp_pkg::SYN_BITS-1:0]  syndrome;
        logic                           run_last;
        logic                           final_byte;
    } byte_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [hdbp_pkg::CW_BITS-1:0]   codeword = '0;
    logic                           stream_end = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [hdbp_pkg::BYTE_BITS-1:0] data_byte;
    logic [hdbp_pkg::SYN_BITS-1:0]  syndrome;
    logic                           run_last;
    logic                           final_byte;

    cw_item_t     codeword_q[$];
    byte_result_t expected_bytes_q[$];
    cw_item_t     next_item;
    logic         in_taken = 1'b0;

    // bit stream carried between codewords
    logic [6:0] pend_bits = '0;
    logic [2:0] pend_cnt = '0;

    int idle_pct = 34;
    int stall_requests = 0;
    int stall_grants = 0;
    int stall_left = 0;

    int mismatches = 0;
    int codewords_taken = 0;
    int bytes_checked = 0;
    int corrected_words = 0;
    int streams_closed = 0;

    hamming_15_11_decode_byte_pack u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .codeword   (codeword),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .syndrome   (syndrome),
        .run_last   (run_last),
        .final_byte (final_byte)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [3:0] syndrome_of(input logic [14:0] cw);
        logic [3:0] s;
        s = '0;
        for (int p = 1; p <= 15; p++)
        begin
            if (cw[p-1])
            begin
                s = s ^ 4'(p);
            end
        end
        return s;
    endfunction

    function automatic logic [14:0] encode_word(input logic [10:0] data);
        logic [14:0] cw;
        logic [3:0]  s;
        int          idx;
        cw  = '0;
        idx = 10;
        for (int p = 1; p <= 15; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                cw[p-1] = data[idx];
                idx--;
            end
        end
        s = syndrome_of(cw);
        for (int b = 0; b < 4; b++)
        begin
            if (s[b])
            begin
                cw[(1 << b) - 1] = 1'b1;
            end
        end
        return cw;
    endfunction

    function automatic logic [14:0] random_codeword();
        logic [14:0] cw;
        int          pick;
        int          p1;
        int          p2;
        cw   = encode_word(11'($urandom));
        pick = $urandom_range(99);
        p1   = $urandom_range(14);
        p2   = (p1 + $urandom_range(1, 14)) % 15;
        if (pick >= 45)
        begin
            cw[p1] = ~cw[p1];
        end
        if (pick >= 82)
        begin
            cw[p2] = ~cw[p2];
        end
        return cw;
    endfunction

    // correct, extract data bits and cut the stream into bytes
    task automatic predict_bytes(input logic [14:0] cw, input logic last);
        logic [3:0]   s;
        logic [14:0]  fixed;
        logic [10:0]  d;
        int           acc;
        int           n;
        int           cnt;
        byte_result_t res[3];
        s     = syndrome_of(cw);
        fixed = cw;
        d     = '0;
        cnt   = 0;
        if (s != 4'd0)
        begin
            fixed[s-1] = ~fixed[s-1];
            corrected_words++;
        end
        for (int p = 1; p <= 15; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                d = {d[9:0], fixed[p-1]};
            end
        end
        acc = (int'(pend_bits) << 11) | int'(d);
        n   = int'(pend_cnt) + 11;
        while (n >= 8)
        begin
            res[cnt] = '{data_byte: 8'(acc >> (n - 8)), syndrome: s,
                         run_last: 1'b0, final_byte: 1'b0};
            cnt++;
            n -= 8;
        end
        acc = acc & ((1 << n) - 1);
        if (last && n > 0)
        begin
            res[cnt] = '{data_byte: 8'(acc << (8 - n)), syndrome: s,
                         run_last: 1'b0, final_byte: 1'b0};
            cnt++;
        end
        res[cnt-1].run_last   = 1'b1;
        res[cnt-1].final_byte = last;
        if (last)
        begin
            n   = 0;
            acc = 0;
            streams_closed++;
        end
        for (int k = 0; k < cnt; k++)
        begin
            expected_bytes_q.push_back(res[k]);
        end
        pend_bits = 7'(acc);
        pend_cnt  = 3'(n);
    endtask

    task automatic check_byte();
        byte_result_t got;
        byte_result_t want;
        got = '{data_byte: data_byte, syndrome: syndrome,
                run_last: run_last, final_byte: final_byte};
        if (expected_bytes_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: unexpected byte %02h syn %0d run_last %0b final %0b",
                         $realtime, got.data_byte, got.syndrome, got.run_last,
                         got.final_byte);
            end
        end
        else
        begin
            want = expected_bytes_q.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: byte %0d expected %02h syn %0d run_last %0b final %0b",
                             $realtime, bytes_checked, want.data_byte, want.syndrome,
                             want.run_last, want.final_byte);
                    $display("%0t: byte %0d got      %02h syn %0d run_last %0b final %0b",
                             $realtime, bytes_checked, got.data_byte, got.syndrome,
                             got.run_last, got.final_byte);
                end
            end
        end
        bytes_checked++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                check_byte();
            end
            if (in_valid && in_ready)
            begin
                predict_bytes(codeword, stream_end);
                codewords_taken++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (codeword_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_item = codeword_q.pop_front();
                codeword   <= next_item.cw;
                stream_end <= next_item.last;
                in_valid   <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (stall_grants != stall_requests)
        begin
            stall_grants++;
            stall_left = STALL_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic add_codeword(input logic [14:0] cw, input logic last);
        cw_item_t it;
        it.cw   = cw;
        it.last = last;
        codeword_q.push_back(it);
    endtask

    task automatic queue_directed();
        // stream of eight: ends exactly on a byte boundary, no padding
        add_codeword(15'h0000, 1'b0);
        add_codeword(15'h7FFF, 1'b0);
        add_codeword(encode_word(11'h7FF) ^ 15'h0001, 1'b0);
        add_codeword(encode_word(11'h000) ^ 15'h0080, 1'b0);
        add_codeword(encode_word(11'h555) ^ 15'h4000, 1'b0);
        add_codeword(encode_word(11'h2AA) ^ 15'h0104, 1'b0);
        add_codeword(encode_word(11'h3C5) ^ 15'h0004, 1'b0);
        add_codeword(encode_word(11'h1A3), 1'b1);
        // single-codeword stream, padded flush
        add_codeword(encode_word(11'h7FF), 1'b1);
        // two-codeword stream with errors in both
        add_codeword(15'h7FFF ^ 15'h2000, 1'b0);
        add_codeword(encode_word(11'h400) ^ 15'h0840, 1'b1);
        add_codeword(15'h7FFF, 1'b1);
        add_codeword(15'h0000, 1'b1);
    endtask

    task automatic queue_random(input int target);
        int added;
        int len;
        added = 0;
        while (added < target)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                begin
                    add_codeword(random_codeword(), k == len - 1);
                end
                added += len;
            end
            else
            begin
                add_codeword(15'($urandom), $urandom_range(3) == 0);
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (codeword_q.size() != 0 || in_valid || expected_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_directed();
        wait_drained();

        // hold both sides busy with no gaps
        idle_pct = 0;
        queue_random(70);
        wait_drained();

        // long receiver stall while codewords keep coming
        idle_pct = 34;
        stall_requests++;
        queue_random(105);
        wait_drained();

        queue_random(105);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Run: %0d codewords (%0d corrected), %0d streams closed, %0d bytes checked",
                 codewords_taken, corrected_words, streams_closed, bytes_checked);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_bytes_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
